### sv/pas_pkg.sv
package pas_pkg;

    localparam int DATA_W = 16;
    localparam int IDX_W  = 8;
    localparam int IDLE_W = 17;

    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    localparam logic [DATA_W-1:0] RST_IDLE_TIMEOUT = 16'd0;
    localparam logic [DATA_W-1:0] RST_SWITCH_LEVEL = 16'd50;
    localparam logic [DATA_W-1:0] RST_FIRST_LEVEL  = 16'd10;

    typedef enum logic [1:0] {
        MODE_X    = 2'd0,
        MODE_Y    = 2'd1,
        MODE_REL  = 2'd2,
        MODE_TICK = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_X    = 2'd0,
        KIND_Y    = 2'd1,
        KIND_PASS = 2'd2,
        KIND_SYNC = 2'd3
    } t_kind;

    typedef enum logic [IDX_W-1:0] {
        REG_IDLE_TIMEOUT = 8'd0,
        REG_SWITCH_LEVEL = 8'd1,
        REG_FIRST_LEVEL  = 8'd2,
        REG_SWITCH_EN    = 8'd3,
        REG_KEEP_REM     = 8'd4
    } t_reg;

    typedef struct packed {
        logic [DATA_W-1:0] idle_timeout;
        logic [DATA_W-1:0] switch_level;
        logic [DATA_W-1:0] first_lock_level;
        logic              switch_enable;
        logic              keep_remainders;
    } t_cfg;

    // Results of one event: slot 0 is X or pass-through, slot 1 is Y, slot 2 is sync.
    typedef struct packed {
        logic [2:0]               slots;
        logic                     pass;
        logic [DATA_W-1:0]        code;
        logic signed [DATA_W-1:0] val_x;
        logic signed [DATA_W-1:0] val_y;
        logic                     sync;
    } t_bundle;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W:0] magnitude(input logic signed [DATA_W-1:0] a);
        logic signed [DATA_W:0] e;
        e = {a[DATA_W-1], a};
        return a[DATA_W-1] ? $unsigned(-e) : $unsigned(e);
    endfunction

endpackage

### sv/pas_if.sv
interface pas_in_if import pas_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic [DATA_W-1:0]        rel_code;
    logic signed [DATA_W-1:0] delta;
    logic                     sync_in;

    modport source (output valid, mode, rel_code, delta, sync_in, input ready);
    modport sink   (input valid, mode, rel_code, delta, sync_in, output ready);
endinterface

interface pas_out_if import pas_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [1:0]               out_kind;
    logic [DATA_W-1:0]        out_code;
    logic signed [DATA_W-1:0] out_value;
    logic                     out_sync;
    logic                     last;

    modport source (output valid, out_kind, out_code, out_value, out_sync, last, input ready);
    modport sink   (input valid, out_kind, out_code, out_value, out_sync, last, output ready);
endinterface

interface pas_cfg_if import pas_pkg::*;;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/pas_cfg.sv
module pas_cfg import pas_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pas_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout     <= RST_IDLE_TIMEOUT;
            r_cfg.switch_level     <= RST_SWITCH_LEVEL;
            r_cfg.first_lock_level <= RST_FIRST_LEVEL;
            r_cfg.switch_enable    <= 1'b0;
            r_cfg.keep_remainders  <= 1'b0;
        end else if (i_cfg.valid) begin
            case (t_reg'(i_cfg.index))
                REG_IDLE_TIMEOUT: r_cfg.idle_timeout     <= i_cfg.data;
                REG_SWITCH_LEVEL: r_cfg.switch_level     <= i_cfg.data;
                REG_FIRST_LEVEL:  r_cfg.first_lock_level <= i_cfg.data;
                REG_SWITCH_EN:    r_cfg.switch_enable    <= i_cfg.data[0];
                REG_KEEP_REM:     r_cfg.keep_remainders  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

endmodule

### sv/pas_core.sv
module pas_core import pas_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pas_in_if.sink  i_evt,
    input  t_cfg    i_cfg,
    input  logic    i_bundle_ready,
    output logic    o_bundle_load,
    output t_bundle o_bundle
);

    logic                     r_in_valid;
    t_mode                    r_in_mode;
    logic [DATA_W-1:0]        r_in_code;
    logic signed [DATA_W-1:0] r_in_delta;
    logic                     r_in_sync;

    logic [IDLE_W-1:0]        r_idle,    n_idle;
    logic                     r_locked,  n_locked;
    logic                     r_lock_x,  n_lock_x;
    logic                     r_lock_y,  n_lock_y;
    logic                     r_dir,     n_dir;
    logic signed [DATA_W-1:0] r_sum_x,   n_sum_x;
    logic signed [DATA_W-1:0] r_sum_y,   n_sum_y;
    logic signed [DATA_W-1:0] r_carry_x, n_carry_x;
    logic signed [DATA_W-1:0] r_carry_y, n_carry_y;

    logic                     consume;
    logic                     idle_clear;
    logic signed [DATA_W-1:0] dx, dy;
    logic [DATA_W:0]          mag_x, mag_y;
    logic                     x_big;
    t_bundle                  bundle;

    assign idle_clear = (i_cfg.idle_timeout != '0) && (r_idle > {1'b0, i_cfg.idle_timeout});

    always_comb begin
        n_idle    = r_idle;
        n_locked  = r_locked;
        n_lock_x  = r_lock_x;
        n_lock_y  = r_lock_y;
        n_dir     = r_dir;
        n_sum_x   = r_sum_x;
        n_sum_y   = r_sum_y;
        n_carry_x = r_carry_x;
        n_carry_y = r_carry_y;
        dx        = '0;
        dy        = '0;
        mag_x     = '0;
        mag_y     = '0;
        x_big     = 1'b0;
        bundle    = '0;

        if (r_in_mode == MODE_TICK) begin
            if (r_idle != IDLE_MAX) begin
                n_idle = r_idle + 1'b1;
            end
        end else begin
            n_idle = '0;
            if (idle_clear) begin
                n_locked = 1'b0;
                n_lock_x = 1'b0;
                n_lock_y = 1'b0;
                n_dir    = 1'b0;
                n_sum_x  = '0;
                n_sum_y  = '0;
                if (!i_cfg.keep_remainders) begin
                    n_carry_x = '0;
                    n_carry_y = '0;
                end
            end

            if (r_in_mode == MODE_REL) begin
                bundle.slots = 3'b001;
                bundle.pass  = 1'b1;
                bundle.code  = r_in_code;
                bundle.val_x = r_in_delta;
                bundle.sync  = r_in_sync;
            end else begin
                if (r_in_mode == MODE_X) begin
                    dx = r_in_delta;
                end else begin
                    dy = r_in_delta;
                end
                if (i_cfg.keep_remainders) begin
                    dx        = sat_add(dx, n_carry_x);
                    dy        = sat_add(dy, n_carry_y);
                    n_carry_x = '0;
                    n_carry_y = '0;
                end

                n_sum_x = sat_add(n_sum_x, dx);
                n_sum_y = sat_add(n_sum_y, dy);
                mag_x   = magnitude(n_sum_x);
                mag_y   = magnitude(n_sum_y);
                x_big   = mag_x > mag_y;

                if (!n_dir && (mag_x >= {1'b0, i_cfg.first_lock_level} ||
                               mag_y >= {1'b0, i_cfg.first_lock_level})) begin
                    n_lock_x = x_big;
                    n_lock_y = !x_big;
                    n_locked = 1'b1;
                    n_dir    = 1'b1;
                end

                if (i_cfg.switch_enable && n_locked &&
                    ((n_lock_x && mag_y > {1'b0, i_cfg.switch_level}) ||
                     (n_lock_y && mag_x > {1'b0, i_cfg.switch_level}))) begin
                    n_lock_x = x_big;
                    n_lock_y = !x_big;
                end

                bundle.val_x = dx;
                bundle.val_y = dy;
                if (n_locked) begin
                    if (n_lock_x) begin
                        bundle.val_y = '0;
                        if (i_cfg.keep_remainders) begin
                            n_carry_y = dy;
                        end
                    end else if (n_lock_y) begin
                        bundle.val_x = '0;
                        if (i_cfg.keep_remainders) begin
                            n_carry_x = dx;
                        end
                    end
                end

                bundle.slots = {r_in_sync, bundle.val_y != '0, bundle.val_x != '0};
            end
        end
    end

    // An item that yields nothing leaves without waiting for the emitter.
    assign consume       = r_in_valid && (bundle.slots == '0 || i_bundle_ready);
    assign o_bundle_load = consume && (bundle.slots != '0);
    assign o_bundle      = bundle;
    assign i_evt.ready   = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in_mode  <= t_mode'(i_evt.mode);
            r_in_code  <= i_evt.rel_code;
            r_in_delta <= i_evt.delta;
            r_in_sync  <= i_evt.sync_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle    <= '0;
            r_locked  <= 1'b0;
            r_lock_x  <= 1'b0;
            r_lock_y  <= 1'b0;
            r_dir     <= 1'b0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_carry_x <= '0;
            r_carry_y <= '0;
        end else if (consume) begin
            r_idle    <= n_idle;
            r_locked  <= n_locked;
            r_lock_x  <= n_lock_x;
            r_lock_y  <= n_lock_y;
            r_dir     <= n_dir;
            r_sum_x   <= n_sum_x;
            r_sum_y   <= n_sum_y;
            r_carry_x <= n_carry_x;
            r_carry_y <= n_carry_y;
        end
    end

    a_lock_one_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_locked |-> (r_lock_x ^ r_lock_y))
        else $error("lock held without exactly one axis");

    a_lock_needs_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_locked |-> r_dir)
        else $error("lock held before a direction was chosen");

    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_mode == MODE_TICK) |=> (r_idle != '0))
        else $error("tick left idle count at zero");

    a_no_empty_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bundle_load |-> i_bundle_ready)
        else $error("result bundle loaded while emitter busy");

endmodule

### sv/pas_emit.sv
module pas_emit import pas_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_bundle_load,
    input  t_bundle  i_bundle,
    output logic     o_bundle_ready,
    pas_out_if.source o_res
);

    logic [2:0]               r_slots, n_slots;
    logic                     r_pass;
    logic [DATA_W-1:0]        r_code;
    logic signed [DATA_W-1:0] r_val_x;
    logic signed [DATA_W-1:0] r_val_y;
    logic                     r_sync;

    logic  fire;
    logic  last;
    t_kind kind;

    assign fire           = o_res.valid && o_res.ready;
    assign last           = (r_slots & (r_slots - 3'd1)) == 3'd0;
    assign o_bundle_ready = (r_slots == 3'd0) || (fire && last);

    always_comb begin
        n_slots = r_slots;
        if (i_bundle_load) begin
            n_slots = i_bundle.slots;
        end else if (fire) begin
            n_slots = r_slots & (r_slots - 3'd1);
        end
    end

    always_comb begin
        kind            = KIND_SYNC;
        o_res.out_code  = '0;
        o_res.out_value = '0;
        o_res.out_sync  = 1'b1;
        if (r_slots[0]) begin
            o_res.out_value = r_val_x;
            if (r_pass) begin
                kind           = KIND_PASS;
                o_res.out_code = r_code;
                o_res.out_sync = r_sync;
            end else begin
                kind           = KIND_X;
                o_res.out_sync = 1'b0;
            end
        end else if (r_slots[1]) begin
            kind            = KIND_Y;
            o_res.out_value = r_val_y;
            o_res.out_sync  = 1'b0;
        end
    end

    assign o_res.valid    = r_slots != 3'd0;
    assign o_res.out_kind = kind;
    assign o_res.last     = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
        end else begin
            r_slots <= n_slots;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bundle_load) begin
            r_pass  <= i_bundle.pass;
            r_code  <= i_bundle.code;
            r_val_x <= i_bundle.val_x;
            r_val_y <= i_bundle.val_y;
            r_sync  <= i_bundle.sync;
        end
    end

    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> $onehot(r_slots))
        else $error("last flag with more results pending");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !o_res.last) |=> o_res.valid)
        else $error("results of one event dropped");

    a_pass_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_pass) |-> (r_slots == 3'b001))
        else $error("pass-through event with extra results");

endmodule

### sv/pointer_axis_snap.sv
// Channel  | Direction | Transaction payload
// i_evt    | in        | mode, rel_code, delta, sync_in
// o_res    | out       | out_kind, out_code, out_value, out_sync, last
// i_cfg    | in        | index, data (register write)
//
// An event is captured in an input register; combinational logic updates the
// lock state and loads a result register with up to three results.
// Results leave one per cycle while o_res is ready; a motion event yields up
// to three results, and ticks and events with no result do not wait for it.
// A new event is accepted while the last result of the previous one is taken.
// Reset (i_rst_n low at a clock edge) clears the lock state, accumulators,
// idle counter and pending results, and restores the register defaults.
// A stall on o_res holds the result register and backs up into i_evt.ready.
module pointer_axis_snap import pas_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pas_in_if.sink    i_evt,
    pas_out_if.source o_res,
    pas_cfg_if.sink   i_cfg
);

    t_cfg    cfg;
    t_bundle bundle;
    logic    bundle_load;
    logic    bundle_ready;

    // Configuration registers. Writes are taken every cycle; the block is
    // expected to be idle while they change.
    pas_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Input register, lock and accumulator state, and the per-event result
    // computation. State advances when the event is consumed: loaded or resultless.
    pas_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_evt          (i_evt),
        .i_cfg          (cfg),
        .i_bundle_ready (bundle_ready),
        .o_bundle_load  (bundle_load),
        .o_bundle       (bundle)
    );

    // Result register that hands out X or pass-through, Y, then sync, marking the final one.
    pas_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bundle_load  (bundle_load),
        .i_bundle       (bundle),
        .o_bundle_ready (bundle_ready),
        .o_res          (o_res)
    );

endmodule
